[hdl/stra_pkg.sv]
// package for the sensor table running average unit
// types, constants and request/status codes; no dependencies
`default_nettype none
package stra_pkg;
	localparam int MAX_SENSORS = 16;
	localparam int WINDOW = 5;
	localparam int SLOT_W = $clog2(MAX_SENSORS);
	localparam int CNT_W = $clog2(MAX_SENSORS + 1);
	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam int WSTORE_DEPTH = MAX_SENSORS * WINDOW;
	localparam int WADDR_W = $clog2(WSTORE_DEPTH);
	localparam int SUM_W = 16 + $clog2(WINDOW + 1) + 1;
	// magnitude of the window sum and reciprocal for the divide by WINDOW
	localparam int ABS_W = SUM_W - 1;
	localparam int DIV_SHIFT = ABS_W + $clog2(WINDOW);
	localparam longint DIV_MUL = ((longint'(1) << DIV_SHIFT) + WINDOW - 1) / WINDOW;
	localparam int MUL_W = $clog2(DIV_MUL + 1);

	localparam logic [1:0] REQ_REGISTER = 2'd0;
	localparam logic [1:0] REQ_SAMPLE = 2'd1;
	localparam logic [1:0] REQ_QUERY = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_UNKNOWN = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;
	localparam logic [1:0] ST_DUP = 2'd3;

	localparam logic CFG_HIGH = 1'b0;
	localparam logic CFG_LOW = 1'b1;

	typedef struct packed {
		logic [1:0] req_type;
		logic [15:0] device_id;
		logic [15:0] room_id;
		logic signed [15:0] reading;
		logic [31:0] timestamp;
	} in_item_t;

	typedef struct packed {
		logic [1:0] status;
		logic [15:0] room;
		logic signed [15:0] average;
		logic average_valid;
		logic too_high;
		logic too_low;
		logic [31:0] last_time;
		logic [4:0] sensor_count;
	} out_item_t;
endpackage
`default_nettype wire

[hdl/sensor_table_running_average_unit.sv]
// sensor table with per-sensor moving average and threshold alarms; depends on stra_pkg
// steps from accept to result: sample search, decide, read, shift, multiply-divide, fetch;
//   new register search, decide, clear, fetch; query or duplicate search, decide, fetch;
//   unknown or full search, decide; one transaction at a time, a new one taken only once the
//   result is accepted, paced by the linear slot search and the window memory shift
// reset: async active low; clears slot valid bits, count, fsm, loads default limits; no clearing pass
`default_nettype none
module sensor_table_running_average_unit (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire stra_pkg::in_item_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output stra_pkg::out_item_t out_data,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [15:0] cfg_wdata
);
	import stra_pkg::*;

	// fsm codes
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_SRCH = 4'd1;
	localparam logic [3:0] S_DEC = 4'd2;
	localparam logic [3:0] S_CLR = 4'd3;
	localparam logic [3:0] S_RD = 4'd4;
	localparam logic [3:0] S_SH = 4'd5;
	localparam logic [3:0] S_DIV = 4'd6;
	localparam logic [3:0] S_FIN = 4'd7;
	localparam logic [3:0] S_OUT = 4'd8;

	logic [3:0] state_q;
	in_item_t req_q;
	out_item_t res_q;
	out_item_t res_nx;
	logic signed [15:0] high_q, low_q;

	// slot table, small arrays read at the search, hit and result indices
	logic [MAX_SENSORS-1:0] used_q;
	logic [15:0] sid_q [MAX_SENSORS];
	logic [15:0] rid_q [MAX_SENSORS];
	logic [FILL_W-1:0] fill_q [MAX_SENSORS];
	logic signed [15:0] avg_q [MAX_SENSORS];
	logic [31:0] time_q [MAX_SENSORS];
	logic [CNT_W-1:0] count_q;

	// window memory, separate read and write addresses, registered read
	logic signed [15:0] wmem [WSTORE_DEPTH];
	logic signed [15:0] wrd_q;
	logic [WADDR_W-1:0] waddr;
	logic wwe;
	logic signed [15:0] wwd;

	// sequencer registers
	logic [SLOT_W-1:0] idx_q;
	logic [SLOT_W:0] scan_q;
	logic found_q, free_ok_q;
	logic [SLOT_W-1:0] hit_q, free_q;
	logic [FILL_W-1:0] k_q;
	logic rd_pend_q;
	logic signed [SUM_W-1:0] sum_q;
	logic [ABS_W-1:0] quo_q;
	logic [1:0] dcnt_q;
	logic neg_q;

	logic [ABS_W+MUL_W-1:0] prod;
	logic reg_full;
	logic div_done;
	logic [FILL_W-1:0] fill_nx;
	logic signed [15:0] avg_nx;

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data = res_q;

	// window address: slot base plus tap
	assign waddr = WADDR_W'(int'(hit_q) * WINDOW + int'(k_q));

	// divide the window magnitude by WINDOW with a reciprocal multiply
	assign prod = (ABS_W+MUL_W)'(quo_q) * (ABS_W+MUL_W)'(DIV_MUL);
	assign div_done = (dcnt_q == 2'd2);
	assign reg_full = (count_q >= CNT_W'(MAX_SENSORS)) || !free_ok_q;

	always_comb begin
		fill_nx = (fill_q[hit_q] < FILL_W'(WINDOW)) ? fill_q[hit_q] + 1'b1 : fill_q[hit_q];
		avg_nx = neg_q ? 16'(-quo_q) : 16'(quo_q);
		if (fill_nx < FILL_W'(WINDOW)) avg_nx = '0;
	end

	// result register contents, built up over the states
	always_comb begin
		res_nx = res_q;
		unique case (state_q)
			S_DEC: begin
				res_nx = '0;
				res_nx.sensor_count = 5'(count_q);
				if (req_q.req_type == REQ_REGISTER) begin
					if (found_q) res_nx.status = ST_DUP;
					else if (reg_full) res_nx.status = ST_FULL;
				end else if (!found_q) begin
					res_nx.status = ST_UNKNOWN;
				end
			end
			S_CLR: res_nx.sensor_count = 5'(count_q);
			S_DIV: begin
				if (div_done) begin
					res_nx.too_high = avg_nx > high_q;
					res_nx.too_low = avg_nx < low_q;
				end
			end
			S_FIN: begin
				res_nx.room = rid_q[idx_q];
				res_nx.average = avg_q[idx_q];
				res_nx.average_valid = (fill_q[idx_q] >= FILL_W'(WINDOW));
				res_nx.last_time = time_q[idx_q];
			end
			default: ;
		endcase
	end

	// write strobe: clear on register, shift down on sample, newest tap last
	always_comb begin
		wwe = 1'b0;
		wwd = '0;
		if (state_q == S_CLR) begin
			wwe = 1'b1;
		end else if (state_q == S_SH && rd_pend_q) begin
			wwe = 1'b1;
			wwd = wrd_q;
		end else if (state_q == S_DIV && dcnt_q == 2'd0) begin
			wwe = 1'b1;
			wwd = req_q.reading;
		end
	end

	always_ff @(posedge clk) begin
		if (wwe) wmem[(state_q == S_SH) ? waddr - WADDR_W'(2) : waddr] <= wwd;
		if (int'(k_q) < WINDOW) wrd_q <= wmem[waddr];
	end

	// during S_SH tap k is read while tap k-1 sits in wrd_q and lands at k-2
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			used_q <= '0;
			count_q <= '0;
			high_q <= 16'sd3200;
			low_q <= 16'sd1920;
		end else begin
			res_q <= res_nx;
			if (cfg_we) begin
				if (cfg_index == CFG_HIGH) high_q <= cfg_wdata;
				else low_q <= cfg_wdata;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q <= in_data;
						scan_q <= '0;
						found_q <= 1'b0;
						free_ok_q <= 1'b0;
						state_q <= S_SRCH;
					end
				end
				// one slot compared per cycle
				S_SRCH: begin
					if (scan_q == (SLOT_W+1)'(MAX_SENSORS)) begin
						state_q <= S_DEC;
					end else begin
						if (used_q[scan_q[SLOT_W-1:0]] && !found_q &&
							sid_q[scan_q[SLOT_W-1:0]] == req_q.device_id) begin
							found_q <= 1'b1;
							hit_q <= scan_q[SLOT_W-1:0];
						end
						if (!used_q[scan_q[SLOT_W-1:0]] && !free_ok_q) begin
							free_ok_q <= 1'b1;
							free_q <= scan_q[SLOT_W-1:0];
						end
						scan_q <= scan_q + 1'b1;
					end
				end
				S_DEC: begin
					k_q <= '0;
					if (req_q.req_type == REQ_REGISTER) begin
						if (found_q) begin
							idx_q <= hit_q;
							state_q <= S_FIN;
						end else if (reg_full) begin
							state_q <= S_OUT;
						end else begin
							hit_q <= free_q;
							used_q[free_q] <= 1'b1;
							sid_q[free_q] <= req_q.device_id;
							rid_q[free_q] <= req_q.room_id;
							fill_q[free_q] <= '0;
							avg_q[free_q] <= '0;
							time_q[free_q] <= '0;
							count_q <= count_q + 1'b1;
							state_q <= S_CLR;
						end
					end else if (!found_q) begin
						state_q <= S_OUT;
					end else if (req_q.req_type == REQ_SAMPLE) begin
						sum_q <= '0;
						rd_pend_q <= 1'b0;
						state_q <= S_RD;
					end else begin
						idx_q <= hit_q;
						state_q <= S_FIN;
					end
				end
				S_CLR: begin
					if (int'(k_q) == WINDOW - 1) begin
						idx_q <= hit_q;
						state_q <= S_FIN;
					end else begin
						k_q <= k_q + 1'b1;
					end
				end
				// start at tap 1; a one-tap window only takes the new reading
				S_RD: begin
					if (WINDOW == 1) begin
						sum_q <= SUM_W'(req_q.reading);
						k_q <= '0;
						dcnt_q <= '0;
						state_q <= S_DIV;
					end else begin
						k_q <= FILL_W'(1);
						state_q <= S_SH;
					end
				end
				// shift taps down by one and accumulate the new window
				S_SH: begin
					if (!rd_pend_q) begin
						rd_pend_q <= 1'b1;
						k_q <= k_q + 1'b1;
					end else if (int'(k_q) == WINDOW) begin
						sum_q <= sum_q + SUM_W'(req_q.reading) + SUM_W'(wrd_q);
						k_q <= FILL_W'(WINDOW - 1);
						dcnt_q <= '0;
						state_q <= S_DIV;
					end else begin
						sum_q <= sum_q + SUM_W'(wrd_q);
						k_q <= k_q + 1'b1;
					end
				end
				// magnitude, reciprocal multiply, then store; quotient truncates toward zero
				S_DIV: begin
					if (dcnt_q == 2'd0) begin
						neg_q <= sum_q[SUM_W-1];
						quo_q <= sum_q[SUM_W-1] ? ABS_W'(-sum_q) : ABS_W'(sum_q);
						dcnt_q <= dcnt_q + 1'b1;
					end else if (!div_done) begin
						quo_q <= ABS_W'(prod >> DIV_SHIFT);
						dcnt_q <= dcnt_q + 1'b1;
					end else begin
						fill_q[hit_q] <= fill_nx;
						avg_q[hit_q] <= avg_nx;
						time_q[hit_q] <= req_q.timestamp;
						idx_q <= hit_q;
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// result only after a request was taken
	a_out_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(state_q) == S_FIN || $past(state_q) == S_DEC)
		else $error("result without request");
	// count never exceeds table size
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_SENSORS)) else $error("count overflow");
	// count matches valid bits
	a_count_bits: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(used_q) == int'(count_q)) else $error("count mismatch");
	// no intake while a result waits
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("ready while result pending");
endmodule
`default_nettype wire

[test/tb.sv]
// testbench for the sensor table running average unit
// self-checking: drives random and directed transactions, predicts every result
// depends on stra_pkg and sensor_table_running_average_unit
`timescale 1ns / 1ps
`default_nettype none
module tb;
	import stra_pkg::*;

	localparam int DRAIN_CYCLES = 80;
	localparam int STALL_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [15:0] cfg_wdata = '0;

	sensor_table_running_average_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// shadow copy of the sensor table
	logic signed [15:0] lim_high, lim_low;
	logic slot_busy [MAX_SENSORS];
	logic [15:0] slot_id [MAX_SENSORS];
	logic [15:0] slot_room [MAX_SENSORS];
	int slot_fill [MAX_SENSORS];
	logic signed [15:0] slot_win [MAX_SENSORS][WINDOW];
	logic signed [15:0] slot_avg [MAX_SENSORS];
	logic [31:0] slot_stamp [MAX_SENSORS];
	int sensors_used;

	in_item_t pending_items[$];
	out_item_t expected_results[$];

	int errors = 0;
	int sent = 0;
	int received = 0;
	int alarms_seen = 0;
	int full_seen = 0;
	int dup_seen = 0;
	bit drive_idle_enable = 1'b1;
	bit sink_idle_enable = 1'b1;
	bit hold_sink = 1'b0;

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("mismatch on result %0d: %s got %h expected %h", received, what, got, want);
		errors++;
	endtask

	function automatic void clear_table();
		lim_high = 16'sd3200;
		lim_low = 16'sd1920;
		sensors_used = 0;
		for (int i = 0; i < MAX_SENSORS; i++) begin
			slot_busy[i] = 1'b0;
		end
	endfunction

	// applies one transaction to the shadow table and returns its result
	function automatic out_item_t table_update(input in_item_t it);
		out_item_t r;
		int s;
		int sum;
		s = -1;
		r = '0;
		for (int i = 0; i < MAX_SENSORS; i++) begin
			if (s < 0 && slot_busy[i] && slot_id[i] == it.device_id) s = i;
		end
		if (it.req_type == REQ_REGISTER) begin
			if (s >= 0) begin
				r.status = ST_DUP;
			end else if (sensors_used >= MAX_SENSORS) begin
				r.status = ST_FULL;
			end else begin
				for (int i = MAX_SENSORS - 1; i >= 0; i--) begin
					if (!slot_busy[i]) s = i;
				end
				slot_busy[s] = 1'b1;
				slot_id[s] = it.device_id;
				slot_room[s] = it.room_id;
				slot_fill[s] = 0;
				for (int k = 0; k < WINDOW; k++) slot_win[s][k] = '0;
				slot_avg[s] = '0;
				slot_stamp[s] = '0;
				sensors_used++;
				r.status = ST_OK;
			end
		end else if (s < 0) begin
			r.status = ST_UNKNOWN;
		end else if (it.req_type == REQ_SAMPLE) begin
			// shift the reading in, oldest drops out
			for (int k = 0; k < WINDOW - 1; k++) slot_win[s][k] = slot_win[s][k + 1];
			slot_win[s][WINDOW - 1] = it.reading;
			sum = 0;
			for (int k = 0; k < WINDOW; k++) sum += int'(slot_win[s][k]);
			if (slot_fill[s] < WINDOW) slot_fill[s]++;
			slot_avg[s] = (slot_fill[s] >= WINDOW) ? 16'(sum / WINDOW) : '0;
			slot_stamp[s] = it.timestamp;
			r.too_high = slot_avg[s] > lim_high;
			r.too_low = slot_avg[s] < lim_low;
		end
		if (s >= 0) begin
			r.room = slot_room[s];
			r.average = slot_avg[s];
			r.average_valid = slot_fill[s] >= WINDOW;
			r.last_time = slot_stamp[s];
		end
		r.sensor_count = 5'(sensors_used);
		return r;
	endfunction

	// driver: offers queued transactions, idles now and then
	always @(posedge clk) begin
		if (in_valid && in_ready) begin
			expected_results.push_back(table_update(in_data));
			sent++;
		end
		if (!in_valid || in_ready) begin
			if (pending_items.size() > 0 &&
					!(drive_idle_enable && $urandom_range(99) < 12)) begin
				in_data <= pending_items.pop_front();
				in_valid <= 1'b1;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// monitor: accepts results and checks each field
	always @(posedge clk) begin
		out_item_t want;
		if (out_valid && out_ready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result with nothing pending", 32'(out_data.status), '0);
			end else begin
				want = expected_results.pop_front();
				if (out_data.status != want.status)
					report_mismatch("status", out_data.status, want.status);
				if (out_data.room != want.room)
					report_mismatch("room", out_data.room, want.room);
				if (out_data.average != want.average)
					report_mismatch("average", out_data.average, want.average);
				if (out_data.average_valid != want.average_valid)
					report_mismatch("average_valid", out_data.average_valid,
						want.average_valid);
				if (out_data.too_high != want.too_high)
					report_mismatch("too_high", out_data.too_high, want.too_high);
				if (out_data.too_low != want.too_low)
					report_mismatch("too_low", out_data.too_low, want.too_low);
				if (out_data.last_time != want.last_time)
					report_mismatch("last_time", out_data.last_time, want.last_time);
				if (out_data.sensor_count != want.sensor_count)
					report_mismatch("sensor_count", out_data.sensor_count,
						want.sensor_count);
				if (want.too_high || want.too_low) alarms_seen++;
				if (want.status == ST_FULL) full_seen++;
				if (want.status == ST_DUP) dup_seen++;
			end
			received++;
		end
		out_ready <= !hold_sink && !(sink_idle_enable && $urandom_range(99) < 12);
	end

	// watchdog: counts cycles with no transaction on either side
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("timeout: no transaction for %0d cycles", STALL_LIMIT);
			$display("Verification failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic in_item_t make_item(input logic [1:0] req, input logic [15:0] id,
			input logic [15:0] room, input logic [15:0] rd, input logic [31:0] ts);
		in_item_t it;
		it.req_type = req;
		it.device_id = id;
		it.room_id = room;
		it.reading = rd;
		it.timestamp = ts;
		return it;
	endfunction

	// random transaction; ids come from a small pool so most hit the table
	function automatic in_item_t random_item(input logic [15:0] pool_base);
		logic [1:0] req;
		logic [15:0] id;
		int pick;
		pick = $urandom_range(99);
		if (pick < 8) req = REQ_REGISTER;
		else if (pick < 85) req = REQ_SAMPLE;
		else if (pick < 97) req = REQ_QUERY;
		else req = 2'd3;
		if ($urandom_range(9) == 0) id = 16'($urandom);
		else id = pool_base + 16'($urandom_range(19));
		return make_item(req, id, 16'($urandom),
			($urandom_range(3) == 0) ? 16'($urandom) : 16'(2560 + $urandom_range(1280) - 640),
			$urandom);
	endfunction

	// waits until every pending transaction has come back, then lets the bench idle for the drain period
	task automatic wait_drained();
		while (pending_items.size() > 0 || in_valid || expected_results.size() > 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(input logic idx, input logic [15:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_HIGH) lim_high = value;
		else lim_low = value;
	endtask

	initial begin
		clear_table();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: unknown sensor, register, duplicate, window fill, field extremes
		pending_items.push_back(make_item(REQ_QUERY, 16'h0000, 16'h0, 16'h0, 32'h0));
		pending_items.push_back(make_item(REQ_SAMPLE, 16'hFFFF, 16'h0, 16'h7FFF, 32'hFFFFFFFF));
		pending_items.push_back(make_item(REQ_REGISTER, 16'h0000, 16'hFFFF, 16'h0, 32'h0));
		pending_items.push_back(make_item(REQ_REGISTER, 16'hFFFF, 16'h0000, 16'h0, 32'h0));
		pending_items.push_back(make_item(REQ_REGISTER, 16'h0000, 16'h1234, 16'h0, 32'h0));
		// too_low raised while the window is still filling
		for (int k = 0; k < 6; k++)
			pending_items.push_back(make_item(REQ_SAMPLE, 16'h0000, 16'h0, 16'h7FFF, 32'(k)));
		for (int k = 0; k < 5; k++)
			pending_items.push_back(make_item(REQ_SAMPLE, 16'hFFFF, 16'h0, 16'h8000,
				32'hFFFFFFF0 + k));
		pending_items.push_back(make_item(REQ_SAMPLE, 16'hFFFF, 16'h0, 16'hFFFF, 32'h1));
		pending_items.push_back(make_item(2'd3, 16'hFFFF, 16'h0, 16'h0, 32'h0));
		pending_items.push_back(make_item(REQ_QUERY, 16'h0000, 16'h0, 16'h0, 32'h0));
		// fill the table, then one more register hits table full
		for (int k = 0; k < MAX_SENSORS - 1; k++)
			pending_items.push_back(make_item(REQ_REGISTER, 16'(16'h5000 + k), 16'(k), 16'h0, 32'h0));
		wait_drained();

		// extreme limits, then the random part on the table as it stands
		write_limit(CFG_HIGH, 16'h7FFF);
		write_limit(CFG_LOW, 16'h8000);
		pending_items.push_back(make_item(REQ_SAMPLE, 16'h0000, 16'h0, 16'h8000, 32'h5));
		wait_drained();
		write_limit(CFG_HIGH, 16'h8000);
		write_limit(CFG_LOW, 16'h7FFF);
		pending_items.push_back(make_item(REQ_SAMPLE, 16'h0000, 16'h0, 16'h0, 32'h6));
		wait_drained();

		// table stays full from here, so random phases use the registered ids
		for (int phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin write_limit(CFG_HIGH, 16'd3200); write_limit(CFG_LOW, 16'd1920); end
				1: begin write_limit(CFG_HIGH, 16'd2600); write_limit(CFG_LOW, 16'd2500); end
				2: begin write_limit(CFG_HIGH, 16'($urandom)); write_limit(CFG_LOW, 16'($urandom)); end
				default: begin write_limit(CFG_HIGH, 16'd0); write_limit(CFG_LOW, 16'd0); end
			endcase
			drive_idle_enable = (phase != 1);
			sink_idle_enable = (phase != 1);
			for (int n = 0; n < 215; n++) pending_items.push_back(random_item(16'h4FFC));
			if (phase == 2) begin
				// hold the receiver off so the block backs up into its input
				hold_sink = 1'b1;
				repeat (400) @(posedge clk);
				hold_sink = 1'b0;
			end
			wait_drained();
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("covered %0d transactions in, %0d results out", sent, received);
		$display("alarms %0d, table-full %0d, duplicate registers %0d, errors %0d",
			alarms_seen, full_seen, dup_seen, errors);
		if (errors == 0 && expected_results.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
`default_nettype wire
